FILE: hdl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for barometric compensation
// Calibration word bundle, mid-pipeline item layout, register map and the
// output saturation limits.
// ----------------------------------------------------------------------------
package bpc_pkg;

   // Register map (word index on the configuration port)
   localparam int unsigned RegIdxW = 3;
   localparam logic [RegIdxW-1:0] RegPresSens = 3'd0;
   localparam logic [RegIdxW-1:0] RegPresOff  = 3'd1;
   localparam logic [RegIdxW-1:0] RegSensTc   = 3'd2;
   localparam logic [RegIdxW-1:0] RegOffTc    = 3'd3;
   localparam logic [RegIdxW-1:0] RegRefTemp  = 3'd4;
   localparam logic [RegIdxW-1:0] RegTempSlope = 3'd5;

   // Field widths
   localparam int unsigned RawW  = 24;
   localparam int unsigned CoefW = 16;
   localparam int unsigned TempW = 15;
   localparam int unsigned PresW = 17;
   localparam int unsigned OffW  = 36;
   localparam int unsigned SensW = 35;

   // Temperature base and output limits
   localparam logic signed [18:0] TempBase = 19'sd2000;
   localparam logic signed [18:0] TempMin  = -19'sd4000;
   localparam logic signed [18:0] TempMax  = 19'sd8500;
   localparam logic [PresW-1:0]   PresMax  = 17'h1FFFF;

   // Calibration words as held by the register block
   typedef struct packed {
      logic [CoefW-1:0] temp_slope;
      logic [CoefW-1:0] ref_temp;
      logic [CoefW-1:0] off_tc;
      logic [CoefW-1:0] sens_tc;
      logic [CoefW-1:0] pres_off;
      logic [CoefW-1:0] pres_sens;
   } cal_type;

   // Item handed from the coefficient half to the pressure half
   typedef struct packed {
      logic signed [TempW-1:0] temp;
      logic signed [OffW-1:0]  off;
      logic signed [SensW-1:0] sens;
      logic [RawW-1:0]         d1;
   } mid_type;

endpackage

FILE: hdl/barometric_pressure_compensation.sv
// Six register stages; each stage advances when it is empty or when its successor moves.
// Throughput: one item per cycle while the result stream is not stalled.
// Widest work per stage: three parallel 25x17 multiplies, or a 24x18 and a 25x17 partial product.
// Reset clears all valid bits and the six calibration words to zero.
// ----------------------------------------------------------------------------
// barometric_pressure_compensation: first-order pressure/temperature compensation
// Turns raw 24-bit pressure and temperature conversions into saturated
// temperature (0.01 degC) and pressure (0.01 mbar) using six calibration words.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [14:0] temperature_centi, [31:15] pressure_centi
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   bpc_pkg::cal_type cal;
   bpc_pkg::mid_type mid_item;
   logic mid_valid;
   logic mid_ready;
   logic signed [bpc_pkg::TempW-1:0] temp_out;
   logic [bpc_pkg::PresW-1:0] pres_out;

   // Calibration registers
   bpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cal         (cal)
   );

   // Temperature, offset and sensitivity
   bpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_d1     (req_tdata[23:0]),
      .in_d2     (req_tdata[47:24]),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_item  (mid_item)
   );

   // Pressure
   bpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_item   (mid_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_temp  (temp_out),
      .out_pres  (pres_out)
   );

   assign rsp_tdata = {pres_out, temp_out};

endmodule

FILE: hdl/bpc_csr.sv
// ----------------------------------------------------------------------------
// bpc_csr: calibration register block
// Six 16-bit calibration words behind a bus port with zero wait states.
// ----------------------------------------------------------------------------
module bpc_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output bpc_pkg::cal_type  cal
);

   bpc_pkg::cal_type cal_ff;
   bpc_pkg::cal_type cal_in;
   logic [bpc_pkg::RegIdxW-1:0] idx;
   logic [bpc_pkg::CoefW-1:0] wdata;
   logic [bpc_pkg::CoefW-1:0] rdata;
   logic wr_en;

   assign idx        = csr_paddr[4:2];
   assign wdata      = csr_pwdata[bpc_pkg::CoefW-1:0];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Decode the write; unmapped words are dropped
   always_comb begin
      cal_in = cal_ff;
      if (wr_en) begin
         case (idx)
            bpc_pkg::RegPresSens:  cal_in.pres_sens  = wdata;
            bpc_pkg::RegPresOff:   cal_in.pres_off   = wdata;
            bpc_pkg::RegSensTc:    cal_in.sens_tc    = wdata;
            bpc_pkg::RegOffTc:     cal_in.off_tc     = wdata;
            bpc_pkg::RegRefTemp:   cal_in.ref_temp   = wdata;
            bpc_pkg::RegTempSlope: cal_in.temp_slope = wdata;
            default:               cal_in = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   // Read back the addressed word
   always_comb begin
      case (idx)
         bpc_pkg::RegPresSens:  rdata = cal_ff.pres_sens;
         bpc_pkg::RegPresOff:   rdata = cal_ff.pres_off;
         bpc_pkg::RegSensTc:    rdata = cal_ff.sens_tc;
         bpc_pkg::RegOffTc:     rdata = cal_ff.off_tc;
         bpc_pkg::RegRefTemp:   rdata = cal_ff.ref_temp;
         bpc_pkg::RegTempSlope: rdata = cal_ff.temp_slope;
         default:               rdata = '0;
      endcase
   end

   assign csr_prdata = {16'h0000, rdata};
   assign cal        = cal_ff;

`ifndef SYNTHESIS
   // Writes to unmapped words leave every calibration word alone
   a_unmapped_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (idx > bpc_pkg::RegTempSlope)) |=> $stable(cal_ff))
      else $error("unmapped write changed calibration");
`endif

endmodule

FILE: hdl/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front: temperature and coefficient stages
// Stage 1 forms dT, stage 2 the three dT products, stage 3 the saturated
// temperature together with the offset and sensitivity terms.
// ----------------------------------------------------------------------------
module bpc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  bpc_pkg::cal_type            cal,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [bpc_pkg::RawW-1:0]    in_d1,
   input  logic [bpc_pkg::RawW-1:0]    in_d2,
   output logic                        out_valid,
   input  logic                        out_ready,
   output bpc_pkg::mid_type            out_item
);

   // Stage 1
   logic                     v1_ff;
   logic [bpc_pkg::RawW-1:0] d1_s1_ff;
   logic signed [24:0]       dt_ff;
   logic signed [24:0]       dt_in;
   // Stage 2
   logic                     v2_ff;
   logic [bpc_pkg::RawW-1:0] d1_s2_ff;
   logic signed [40:0]       pt_ff, po_ff, ps_ff;
   logic signed [40:0]       pt_in, po_in, ps_in;
   // Stage 3
   logic                     v3_ff;
   bpc_pkg::mid_type         item_ff;
   bpc_pkg::mid_type         item_in;
   logic signed [18:0]       temp_w;

   logic adv1, adv2, adv3;

   // A stage advances when it is empty or its successor takes its item
   assign adv3     = !v3_ff || out_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   // dT = D2 - C5 * 256
   assign dt_in = $signed({1'b0, in_d2}) - $signed({1'b0, cal.ref_temp, 8'h00});

   // dT times C6, C4 and C3
   assign pt_in = dt_ff * $signed({1'b0, cal.temp_slope});
   assign po_in = dt_ff * $signed({1'b0, cal.off_tc});
   assign ps_in = dt_ff * $signed({1'b0, cal.sens_tc});

   // Temperature with clamp, offset and sensitivity sums
   always_comb begin
      temp_w = $signed({pt_ff[40], pt_ff[40:23]}) + bpc_pkg::TempBase;
      item_in.d1 = d1_s2_ff;
      if (temp_w < bpc_pkg::TempMin) begin
         item_in.temp = bpc_pkg::TempMin[14:0];
      end else if (temp_w > bpc_pkg::TempMax) begin
         item_in.temp = bpc_pkg::TempMax[14:0];
      end else begin
         item_in.temp = temp_w[14:0];
      end
      item_in.off  = $signed({3'b000, cal.pres_off, 17'h00000})
                   + $signed({po_ff[40], po_ff[40:6]});
      item_in.sens = $signed({3'b000, cal.pres_sens, 16'h0000})
                   + $signed({ps_ff[40], ps_ff[40:7]});
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= in_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         d1_s1_ff <= in_d1;
         dt_ff    <= dt_in;
      end
      if (adv2 && v1_ff) begin
         d1_s2_ff <= d1_s1_ff;
         pt_ff    <= pt_in;
         po_ff    <= po_in;
         ps_ff    <= ps_in;
      end
      if (adv3 && v2_ff) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = item_ff;

`ifndef SYNTHESIS
   // Temperature leaving this half is always inside its clamp range
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (item_ff.temp >= -15'sd4000 && item_ff.temp <= 15'sd8500))
      else $error("temperature outside clamp range");
`endif

endmodule

FILE: hdl/bpc_back.sv
// ----------------------------------------------------------------------------
// bpc_back: pressure stages
// Stage 4 forms two partial products of D1 and SENS, stage 5 joins them,
// stage 6 removes the offset, scales and clamps the pressure.
// ----------------------------------------------------------------------------
module bpc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  bpc_pkg::mid_type              in_item,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [bpc_pkg::TempW-1:0] out_temp,
   output logic [bpc_pkg::PresW-1:0]     out_pres
);

   // Stage 4
   logic                             v4_ff;
   logic [41:0]                      plo_ff, plo_in;
   logic signed [40:0]               phi_ff, phi_in;
   logic signed [bpc_pkg::OffW-1:0]  off_s4_ff;
   logic signed [bpc_pkg::TempW-1:0] temp_s4_ff;
   // Stage 5
   logic                             v5_ff;
   logic signed [58:0]               full_ff, full_in;
   logic signed [bpc_pkg::OffW-1:0]  off_s5_ff;
   logic signed [bpc_pkg::TempW-1:0] temp_s5_ff;
   // Stage 6
   logic                             v6_ff;
   logic signed [38:0]               diff_in;
   logic [bpc_pkg::PresW-1:0]        pres_ff, pres_in;
   logic signed [bpc_pkg::TempW-1:0] temp_ff;

   logic adv4, adv5, adv6;

   assign adv6     = !v6_ff || out_ready;
   assign adv5     = !v5_ff || adv6;
   assign adv4     = !v4_ff || adv5;
   assign in_ready = adv4;

   // Split SENS into a low unsigned and a high signed slice
   assign plo_in = in_item.d1 * in_item.sens[17:0];
   assign phi_in = $signed({1'b0, in_item.d1}) * $signed(in_item.sens[34:18]);

   // Rejoin the slices into D1 * SENS
   assign full_in = $signed({phi_ff, 18'h00000}) + $signed({17'h00000, plo_ff});

   // (D1*SENS/2^21 - OFF) / 2^15 with clamp
   always_comb begin
      diff_in = $signed({full_ff[58], full_ff[58:21]})
              - $signed({{3{off_s5_ff[bpc_pkg::OffW-1]}}, off_s5_ff});
      if (diff_in[38]) begin
         pres_in = '0;
      end else if (|diff_in[37:32]) begin
         pres_in = bpc_pkg::PresMax;
      end else begin
         pres_in = diff_in[31:15];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (adv4) begin
            v4_ff <= in_valid;
         end
         if (adv5) begin
            v5_ff <= v4_ff;
         end
         if (adv6) begin
            v6_ff <= v5_ff;
         end
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv4 && in_valid) begin
         plo_ff     <= plo_in;
         phi_ff     <= phi_in;
         off_s4_ff  <= in_item.off;
         temp_s4_ff <= in_item.temp;
      end
      if (adv5 && v4_ff) begin
         full_ff    <= full_in;
         off_s5_ff  <= off_s4_ff;
         temp_s5_ff <= temp_s4_ff;
      end
      if (adv6 && v5_ff) begin
         pres_ff <= pres_in;
         temp_ff <= temp_s5_ff;
      end
   end

   assign out_valid = v6_ff;
   assign out_temp  = temp_ff;
   assign out_pres  = pres_ff;

`ifndef SYNTHESIS
   // A negative pressure difference clamps to zero
   a_pres_floor: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && adv6 && diff_in[38]) |=> (pres_ff == '0))
      else $error("negative pressure not clamped");

   // A stalled result is held, not dropped or replaced
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (v6_ff && !out_ready) |=> (v6_ff && $stable(pres_ff) && $stable(temp_ff)))
      else $error("stalled result changed");

   // An item in the join stage moves on whenever the output stage is free
   a_join_moves: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && !v6_ff) |=> v6_ff)
      else $error("join stage item did not advance");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for barometric_pressure_compensation
// Streams raw pressure/temperature pairs through the block under several
// calibration sets and idle patterns, and compares every compensated
// reading with a local integer-shift predictor.
// ----------------------------------------------------------------------------
module testbench;

   // Register indexes past the calibration words; writes there are dropped
   localparam logic [bpc_pkg::RegIdxW-1:0] RegSpareLo = 3'd6;
   localparam logic [bpc_pkg::RegIdxW-1:0] RegSpareHi = 3'd7;
   localparam int unsigned NumCoef = 6;
   localparam bit [bpc_pkg::RawW-1:0] RawMax = '1;
   localparam int unsigned DrainCycles = 12;
   localparam int unsigned StallLimit = 2000;
   localparam int unsigned ItemsPerPhase = 210;
   localparam int unsigned RandomPhases = 6;

   typedef struct {
      bit signed [bpc_pkg::TempW-1:0] temp;
      bit [bpc_pkg::PresW-1:0]        pres;
   } reading_type;

   // Predicted compensated readings, checked in order of arrival
   class reading_tracker;
      bit [bpc_pkg::CoefW-1:0] coef [NumCoef];
      reading_type    pending [$];
      int             errors;

      function void set_coef(int unsigned idx, bit [31:0] value);
         if (idx < NumCoef) coef[idx] = value[bpc_pkg::CoefW-1:0];
      endfunction

      // First-order compensation; >>> on longint floors toward minus infinity
      function reading_type compensate(bit [bpc_pkg::RawW-1:0] d1_raw,
                                       bit [bpc_pkg::RawW-1:0] d2_raw);
         reading_type r;
         longint d1, d2, dt, temp, off, sens, p;
         longint c1, c2, c3, c4, c5, c6;
         d1 = d1_raw;
         d2 = d2_raw;
         c1 = coef[bpc_pkg::RegPresSens];
         c2 = coef[bpc_pkg::RegPresOff];
         c3 = coef[bpc_pkg::RegSensTc];
         c4 = coef[bpc_pkg::RegOffTc];
         c5 = coef[bpc_pkg::RegRefTemp];
         c6 = coef[bpc_pkg::RegTempSlope];
         dt   = d2 - c5 * 256;
         temp = longint'(bpc_pkg::TempBase) + ((dt * c6) >>> 23);
         off  = c2 * 131072 + ((c4 * dt) >>> 6);
         sens = c1 * 65536 + ((c3 * dt) >>> 7);
         p    = (((d1 * sens) >>> 21) - off) >>> 15;
         if (temp < longint'(bpc_pkg::TempMin)) temp = bpc_pkg::TempMin;
         if (temp > longint'(bpc_pkg::TempMax)) temp = bpc_pkg::TempMax;
         if (p < 0) p = 0;
         if (p > longint'(bpc_pkg::PresMax)) p = bpc_pkg::PresMax;
         r.temp = temp[bpc_pkg::TempW-1:0];
         r.pres = p[bpc_pkg::PresW-1:0];
         return r;
      endfunction

      function void note_reading(bit [bpc_pkg::RawW-1:0] d1, bit [bpc_pkg::RawW-1:0] d2);
         pending.push_back(compensate(d1, d2));
      endfunction

      function void check_result(bit [31:0] data);
         reading_type want;
         if (pending.size() == 0) begin
            $error("unexpected result item: tdata %h", data);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (data[bpc_pkg::TempW-1:0] !== want.temp) begin
            $error("temperature_centi: expected %0d, actual %0d",
                   want.temp, $signed(data[bpc_pkg::TempW-1:0]));
            errors++;
         end
         if (data[bpc_pkg::TempW +: bpc_pkg::PresW] !== want.pres) begin
            $error("pressure_centi: expected %0d, actual %0d",
                   want.pres, data[bpc_pkg::TempW +: bpc_pkg::PresW]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;    // [23:0] raw_pressure, [47:24] raw_temperature
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [14:0] temperature_centi, [31:15] pressure_centi
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   reading_tracker tracker = new();
   bit [bpc_pkg::CoefW-1:0] cal_set [NumCoef];
   int             send_calm;
   int             recv_calm;
   int unsigned    stall_count;

   barometric_pressure_compensation uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Idle length per item, with occasional stretches of back-to-back items
   function int pick_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(15, 60);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   // Write one register through a setup and an access phase
   task automatic csr_write(logic [bpc_pkg::RegIdxW-1:0] idx, bit [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      tracker.set_coef(idx, value);
   endtask

   // Hold until every reading is back, then load cal_set with junk upper bits
   task automatic load_calibration();
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      for (int i = bpc_pkg::RegPresSens; i <= bpc_pkg::RegTempSlope; i++)
         csr_write(3'(i), {16'($urandom), cal_set[i]});
   endtask

   // Offer one item and hold it until accepted
   task automatic send_reading(bit [bpc_pkg::RawW-1:0] d1, bit [bpc_pkg::RawW-1:0] d2);
      int gap;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {d2, d1};
      do @(posedge clock); while (!req_tready);
      tracker.note_reading(d1, d2);
   endtask

   // Random pair, mostly around the reference temperature and mid pressure
   task automatic send_random_reading();
      bit [bpc_pkg::RawW-1:0] d1, d2;
      longint        t;
      if ($urandom_range(0, 3) == 0) begin
         d2 = 24'($urandom);
      end else begin
         t = longint'(tracker.coef[bpc_pkg::RegRefTemp]) * 256
             + longint'($urandom_range(0, 1 << 22)) - (1 << 21);
         if (t < 0) t = 0;
         if (t > RawMax) t = RawMax;
         d2 = t[bpc_pkg::RawW-1:0];
      end
      if ($urandom_range(0, 2) == 0) d1 = 24'($urandom);
      else d1 = 24'($urandom_range(6000000, 12000000));
      send_reading(d1, d2);
   endtask

   task automatic send_corners();
      send_reading('0, '0);
      send_reading(RawMax, RawMax);
      send_reading(RawMax, '0);
      send_reading('0, RawMax);
   endtask

   task automatic pick_random_calibration(int phase);
      for (int i = 0; i < NumCoef; i++) begin
         case (phase % 3)
            0: cal_set[i] = cal_set[i] ^ 16'($urandom_range(0, 4095));
            1: cal_set[i] = 16'($urandom);
            default: begin
               case ($urandom_range(0, 2))
                  0: cal_set[i] = '0;
                  1: cal_set[i] = '1;
                  default: cal_set[i] = 16'($urandom);
               endcase
            end
         endcase
      end
   endtask

   // Main stimulus
   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Calibration words at their reset value of zero
      send_corners();

      // Typical calibration: nominal pair, both saturations on each output
      cal_set = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
      req_tvalid <= 1'b0;
      load_calibration();
      send_reading(24'd9085466, 24'd8569150);
      send_corners();
      send_reading('0, 24'd8569150);
      send_reading(RawMax, 24'd8569150);
      send_reading(24'd9085466, '0);
      send_reading(24'd9085466, RawMax);

      // Writes past the last register must leave the words alone
      req_tvalid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr_write(RegSpareLo, $urandom);
      csr_write(RegSpareHi, $urandom);
      send_reading(24'd9085466, 24'd8569150);

      // All calibration words at full scale
      for (int i = 0; i < NumCoef; i++) cal_set[i] = '1;
      req_tvalid <= 1'b0;
      load_calibration();
      send_corners();
      send_reading(24'd8388608, 24'd16776960);

      // Random items under a series of calibration sets
      cal_set = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
      for (int ph = 0; ph < RandomPhases; ph++) begin
         pick_random_calibration(ph);
         req_tvalid <= 1'b0;
         load_calibration();
         for (int n = 0; n < ItemsPerPhase; n++) send_random_reading();
      end
      req_tvalid <= 1'b0;

      // Drain and report
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (tracker.errors == 0)
         $display("barometric_pressure_compensation regression: pass");
      else
         $display("barometric_pressure_compensation regression: fail");
      $finish;
   end

   // Result side: stall at random, check each accepted item
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         int gap;
         gap = pick_gap(recv_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker.check_result(rsp_tdata);
      end
   end

   // Watchdog: count cycles in which no item is accepted and no register access completes
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready)) begin
         stall_count <= 0;
      end else if (stall_count >= StallLimit) begin
         $display("barometric_pressure_compensation regression: fail");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

endmodule
